// ===== rtl/rwvc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwvc_pkg
// Types and codes shared by the relay write-verify controller.
// ----------------------------------------------------------------------------
package rwvc_pkg;

    localparam int NUM_COUNTERS = 7;

    typedef enum logic [2:0] {
        CMD_SET_TARGET = 3'd0,
        CMD_PREPARE    = 3'd1,
        CMD_SENT       = 3'd2,
        CMD_FRAME      = 3'd3,
        CMD_TIMEOUT    = 3'd4,
        CMD_STATUS     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_IDLE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DLY_POLL     = 2'd0,
        DLY_RETRY    = 2'd1,
        DLY_READBACK = 2'd2
    } delay_t;

    // frame status codes
    localparam logic [2:0] FST_OK      = 3'd0;
    localparam logic [2:0] FST_OTHER   = 3'd3;
    localparam logic [2:0] FST_FOREIGN = 3'd4;
    localparam logic [2:0] FST_ECHO    = 3'd5;

    // recorded frame result codes
    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_CRC   = 2'd2;
    localparam logic [1:0] RES_OTHER = 2'd3;

    // counter indexes
    localparam logic [2:0] CNT_WRITE   = 3'd0;
    localparam logic [2:0] CNT_ACK     = 3'd1;
    localparam logic [2:0] CNT_READ    = 3'd2;
    localparam logic [2:0] CNT_TIMEOUT = 3'd3;
    localparam logic [2:0] CNT_PARSE   = 3'd4;
    localparam logic [2:0] CNT_CRC     = 3'd5;
    localparam logic [2:0] CNT_ERRRUN  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_POLL  = 2'd0;
    localparam logic [1:0] CFG_RETRY = 2'd1;
    localparam logic [1:0] CFG_STALE = 2'd2;

    localparam logic [30:0] POLL_RESET  = 31'd1000;
    localparam logic [30:0] RETRY_RESET = 31'd200;
    localparam logic [30:0] STALE_RESET = 31'd3000;

    typedef struct packed {
        logic [2:0]  command;
        logic        wanted_on;
        logic [31:0] now_tick;
        logic [31:0] rx_tick;
        logic [2:0]  frame_status;
        logic        read_bit;
        logic [2:0]  counter_select;
    } in_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  request_kind;
        logic        request_value;
        logic [1:0]  pending_kind;
        logic        online;
        logic        sample_fresh;
        logic        verified;
        logic        observed_state;
        logic        target_state;
        logic [1:0]  last_result;
        logic        result_valid;
        logic [31:0] counter_value;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_wr_t;

endpackage

// ===== rtl/rwvc_core.sv =====
// ----------------------------------------------------------------------------
// rwvc_core
// Controller state, configuration registers and the per-event update.
// ----------------------------------------------------------------------------
module rwvc_core #(
    parameter int READBACK_DELAY = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             evt_fire,
    input  rwvc_pkg::in_t    evt,
    input  rwvc_pkg::cfg_wr_t cfg,
    output rwvc_pkg::out_t   result
);

    localparam logic [30:0] RB_DELAY = 31'(READBACK_DELAY);

    logic [30:0] poll_reg, retry_reg, stale_reg;

    logic                   target_on_reg,       target_on_next;
    logic [31:0]            target_gen_reg,      target_gen_next;
    logic                   need_write_reg,      need_write_next;
    logic                   readback_next_reg,   readback_next_next;
    rwvc_pkg::kind_t        pending_reg,         pending_next;
    rwvc_pkg::kind_t        prepared_reg,        prepared_next;
    logic                   prep_value_reg,      prep_value_next;
    logic [31:0]            prep_gen_reg,        prep_gen_next;
    logic [31:0]            pend_gen_reg,        pend_gen_next;
    logic [31:0]            sent_gen_reg,        sent_gen_next;
    logic [31:0]            compl_time_reg,      compl_time_next;
    rwvc_pkg::delay_t       delay_reg,           delay_next;
    logic                   seen_resp_reg,       seen_resp_next;
    logic                   seen_read_reg,       seen_read_next;
    logic [31:0]            succ_time_reg,       succ_time_next;
    logic [31:0]            read_time_reg,       read_time_next;
    logic                   rb_value_reg,        rb_value_next;
    logic                   verify_reg,          verify_next;
    logic [1:0]             res_code_reg,        res_code_next;
    logic                   res_seen_reg,        res_seen_next;
    logic [31:0]            cnt_reg [rwvc_pkg::NUM_COUNTERS];
    logic [31:0]            cnt_next [rwvc_pkg::NUM_COUNTERS];

    logic        acc;
    logic [30:0] cur_delay;
    logic [31:0] prep_age, succ_age, read_age;
    logic [2:0]  fstat;
    logic [1:0]  fcode;
    logic        onl, samp;

    always_comb begin
        case (delay_reg)
            rwvc_pkg::DLY_RETRY:    cur_delay = retry_reg;
            rwvc_pkg::DLY_READBACK: cur_delay = RB_DELAY;
            default:                cur_delay = poll_reg;
        endcase
    end

    assign prep_age = evt.now_tick - compl_time_reg;

    // own echo counts as ok; unknown codes fold into other error
    always_comb begin
        fstat = (evt.frame_status == rwvc_pkg::FST_ECHO) ? rwvc_pkg::FST_OK : evt.frame_status;
        fcode = (fstat <= rwvc_pkg::FST_OTHER) ? fstat[1:0] : rwvc_pkg::RES_OTHER;
    end

    always_comb begin
        target_on_next     = target_on_reg;
        target_gen_next    = target_gen_reg;
        need_write_next    = need_write_reg;
        readback_next_next = readback_next_reg;
        pending_next       = pending_reg;
        prepared_next      = prepared_reg;
        prep_value_next    = prep_value_reg;
        prep_gen_next      = prep_gen_reg;
        pend_gen_next      = pend_gen_reg;
        sent_gen_next      = sent_gen_reg;
        compl_time_next    = compl_time_reg;
        delay_next         = delay_reg;
        seen_resp_next     = seen_resp_reg;
        seen_read_next     = seen_read_reg;
        succ_time_next     = succ_time_reg;
        read_time_next     = read_time_reg;
        rb_value_next      = rb_value_reg;
        verify_next        = verify_reg;
        res_code_next      = res_code_reg;
        res_seen_next      = res_seen_reg;
        cnt_next           = cnt_reg;
        acc                = 1'b0;

        unique case (evt.command)
            rwvc_pkg::CMD_SET_TARGET: begin
                if (target_on_reg != evt.wanted_on) begin
                    target_on_next  = evt.wanted_on;
                    target_gen_next = target_gen_reg + 32'd1;
                    verify_next     = 1'b0;
                    need_write_next = 1'b1;
                    acc             = 1'b1;
                end
            end
            rwvc_pkg::CMD_PREPARE: begin
                if (pending_reg == rwvc_pkg::KIND_IDLE && prep_age >= {1'b0, cur_delay}) begin
                    prep_gen_next = target_gen_reg;
                    if (need_write_reg && !readback_next_reg) begin
                        prepared_next   = rwvc_pkg::KIND_WRITE;
                        prep_value_next = target_on_reg;
                    end else begin
                        prepared_next = rwvc_pkg::KIND_READ;
                    end
                    acc = 1'b1;
                end
            end
            rwvc_pkg::CMD_SENT: begin
                if (pending_reg == rwvc_pkg::KIND_IDLE && prepared_reg != rwvc_pkg::KIND_IDLE) begin
                    pending_next  = prepared_reg;
                    prepared_next = rwvc_pkg::KIND_IDLE;
                    pend_gen_next = prep_gen_reg;
                    if (prepared_reg == rwvc_pkg::KIND_WRITE) begin
                        cnt_next[rwvc_pkg::CNT_WRITE] = cnt_reg[rwvc_pkg::CNT_WRITE] + 32'd1;
                        sent_gen_next = prep_gen_reg;
                        verify_next   = 1'b0;
                    end
                    acc = 1'b1;
                end
            end
            rwvc_pkg::CMD_FRAME: begin
                if (pending_reg != rwvc_pkg::KIND_IDLE
                    && evt.frame_status != rwvc_pkg::FST_FOREIGN
                    && !(evt.frame_status == rwvc_pkg::FST_ECHO
                         && pending_reg == rwvc_pkg::KIND_READ)) begin
                    res_seen_next = 1'b1;
                    res_code_next = fcode;
                    if (fcode == rwvc_pkg::RES_OK) begin
                        seen_resp_next = 1'b1;
                        succ_time_next = evt.rx_tick;
                        if (pending_reg == rwvc_pkg::KIND_WRITE) begin
                            cnt_next[rwvc_pkg::CNT_ACK] = cnt_reg[rwvc_pkg::CNT_ACK] + 32'd1;
                        end else begin
                            seen_read_next = 1'b1;
                            cnt_next[rwvc_pkg::CNT_READ] = cnt_reg[rwvc_pkg::CNT_READ] + 32'd1;
                            cnt_next[rwvc_pkg::CNT_ERRRUN] = '0;
                            read_time_next = evt.rx_tick;
                            rb_value_next  = evt.read_bit;
                            verify_next    = (pend_gen_reg == target_gen_reg)
                                             && (sent_gen_reg == target_gen_reg)
                                             && (evt.read_bit == target_on_reg);
                            need_write_next = !verify_next;
                        end
                    end else begin
                        cnt_next[rwvc_pkg::CNT_ERRRUN] = cnt_reg[rwvc_pkg::CNT_ERRRUN] + 32'd1;
                        cnt_next[rwvc_pkg::CNT_PARSE]  = cnt_reg[rwvc_pkg::CNT_PARSE] + 32'd1;
                        if (fcode == rwvc_pkg::RES_CRC) begin
                            cnt_next[rwvc_pkg::CNT_CRC] = cnt_reg[rwvc_pkg::CNT_CRC] + 32'd1;
                        end
                    end
                    readback_next_next = (pending_reg == rwvc_pkg::KIND_WRITE);
                    pending_next       = rwvc_pkg::KIND_IDLE;
                    compl_time_next    = evt.now_tick;
                    delay_next         = (pending_reg == rwvc_pkg::KIND_WRITE)
                                         ? rwvc_pkg::DLY_READBACK : rwvc_pkg::DLY_POLL;
                    acc                = 1'b1;
                end
            end
            rwvc_pkg::CMD_TIMEOUT: begin
                if (pending_reg != rwvc_pkg::KIND_IDLE) begin
                    cnt_next[rwvc_pkg::CNT_TIMEOUT] = cnt_reg[rwvc_pkg::CNT_TIMEOUT] + 32'd1;
                    cnt_next[rwvc_pkg::CNT_ERRRUN]  = cnt_reg[rwvc_pkg::CNT_ERRRUN] + 32'd1;
                    readback_next_next = (pending_reg == rwvc_pkg::KIND_WRITE);
                    pending_next       = rwvc_pkg::KIND_IDLE;
                    compl_time_next    = evt.now_tick;
                    delay_next         = rwvc_pkg::DLY_RETRY;
                    acc                = 1'b1;
                end
            end
            rwvc_pkg::CMD_STATUS: begin
                acc = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign succ_age = evt.now_tick - succ_time_next;
    assign read_age = evt.now_tick - read_time_next;
    assign onl  = seen_resp_next && (succ_age <= {1'b0, stale_reg});
    assign samp = seen_read_next && (read_age <= {1'b0, stale_reg});

    always_comb begin
        result.accepted       = acc;
        result.request_kind   = prepared_next;
        result.request_value  = (prepared_next == rwvc_pkg::KIND_WRITE) && prep_value_next;
        result.pending_kind   = pending_next;
        result.online         = onl;
        result.sample_fresh   = samp;
        result.verified       = samp && verify_next;
        result.observed_state = rb_value_next;
        result.target_state   = target_on_next;
        result.last_result    = res_code_next;
        result.result_valid   = res_seen_next;
        result.counter_value  = (evt.counter_select < 3'(rwvc_pkg::NUM_COUNTERS))
                                ? cnt_next[evt.counter_select] : target_gen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_reg  <= rwvc_pkg::POLL_RESET;
            retry_reg <= rwvc_pkg::RETRY_RESET;
            stale_reg <= rwvc_pkg::STALE_RESET;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                rwvc_pkg::CFG_POLL:  poll_reg  <= cfg.data[30:0];
                rwvc_pkg::CFG_RETRY: retry_reg <= cfg.data[30:0];
                rwvc_pkg::CFG_STALE: stale_reg <= cfg.data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_on_reg     <= 1'b0;
            target_gen_reg    <= 32'd1;
            need_write_reg    <= 1'b1;
            readback_next_reg <= 1'b0;
            pending_reg       <= rwvc_pkg::KIND_IDLE;
            prepared_reg      <= rwvc_pkg::KIND_IDLE;
            prep_value_reg    <= 1'b0;
            prep_gen_reg      <= '0;
            pend_gen_reg      <= '0;
            sent_gen_reg      <= '0;
            compl_time_reg    <= '0;
            delay_reg         <= rwvc_pkg::DLY_POLL;
            seen_resp_reg     <= 1'b0;
            seen_read_reg     <= 1'b0;
            succ_time_reg     <= '0;
            read_time_reg     <= '0;
            rb_value_reg      <= 1'b0;
            verify_reg        <= 1'b0;
            res_code_reg      <= rwvc_pkg::RES_OK;
            res_seen_reg      <= 1'b0;
            for (int i = 0; i < rwvc_pkg::NUM_COUNTERS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (evt_fire) begin
            target_on_reg     <= target_on_next;
            target_gen_reg    <= target_gen_next;
            need_write_reg    <= need_write_next;
            readback_next_reg <= readback_next_next;
            pending_reg       <= pending_next;
            prepared_reg      <= prepared_next;
            prep_value_reg    <= prep_value_next;
            prep_gen_reg      <= prep_gen_next;
            pend_gen_reg      <= pend_gen_next;
            sent_gen_reg      <= sent_gen_next;
            compl_time_reg    <= compl_time_next;
            delay_reg         <= delay_next;
            seen_resp_reg     <= seen_resp_next;
            seen_read_reg     <= seen_read_next;
            succ_time_reg     <= succ_time_next;
            read_time_reg     <= read_time_next;
            rb_value_reg      <= rb_value_next;
            verify_reg        <= verify_next;
            res_code_reg      <= res_code_next;
            res_seen_reg      <= res_seen_next;
            cnt_reg           <= cnt_next;
        end
    end

endmodule

// ===== rtl/relay_write_verify_controller.sv =====
// ----------------------------------------------------------------------------
// relay_write_verify_controller
// Keeps one relay coil in step with a target through write and readback.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------
//  s_       | in        | s_valid / s_ready    | s_data  (rwvc_pkg::in_t)
//  m_       | out       | m_valid / m_ready    | m_data  (rwvc_pkg::out_t)
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One event per cycle while m_ is not stalled; a result passes from the input register
//  through the state update into the result register before it is valid on m_.
//  The state update in rwvc_core is combinational and registered as each event is processed.
//  Synchronous active-low reset; config is always ready and is registered in rwvc_core.
//  A stalled m_ stage holds the input register full; s_ready drops only then.
// ----------------------------------------------------------------------------
module relay_write_verify_controller #(
    parameter int READBACK_DELAY = 3
) (
    input  logic           aclk,
    input  logic           aresetn,

    input  logic           s_valid,
    output logic           s_ready,
    input  rwvc_pkg::in_t  s_data,

    output logic           m_valid,
    input  logic           m_ready,
    output rwvc_pkg::out_t m_data,

    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    logic              in_valid_reg;
    rwvc_pkg::in_t     in_data_reg;
    logic              out_valid_reg;
    rwvc_pkg::out_t    out_data_reg;
    logic              advance;
    rwvc_pkg::out_t    core_result;
    rwvc_pkg::cfg_wr_t cfg_wr;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        cfg_wr.valid = cfg_valid;
        cfg_wr.index = cfg_index;
        cfg_wr.data  = cfg_data;
    end

    rwvc_core #(
        .READBACK_DELAY(READBACK_DELAY)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt_fire (advance),
        .evt      (in_data_reg),
        .cfg      (cfg_wr),
        .result   (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

`ifndef SYNTH
    // a processed request always lands in the result register
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed request did not produce a result");

    a_verified_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.verified || m_data.sample_fresh))
        else $error("verified without a fresh sample");

    a_value_only_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.request_kind != rwvc_pkg::KIND_WRITE) |-> !m_data.request_value)
        else $error("request value set on a non-write request");
`endif

endmodule

// ===== tb/tb_relay_write_verify_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_relay_write_verify_controller
// Self-checking bench for the relay write-verify controller. Events go in
// on the s_ channel with random gaps, results are taken on m_ with random
// stalls, and each result is checked field by field against a cycle-free
// predictor that is updated as each request is accepted. A directed run
// covers the corner cases. Random write/readback transactions then run
// under several interval settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_relay_write_verify_controller;

    localparam int          READBACK_GAP   = 3;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          REPORT_LIMIT   = 10;

    // codes the package leaves unnamed
    localparam logic [2:0]  CMD_BAD_LO  = 3'd6;
    localparam logic [2:0]  CMD_BAD_HI  = 3'd7;
    localparam logic [2:0]  FST_BADLEN  = 3'd1;
    localparam logic [2:0]  FST_CRC     = 3'd2;
    localparam logic [2:0]  FST_RSVD_6  = 3'd6;
    localparam logic [2:0]  FST_RSVD_7  = 3'd7;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;

    logic           aclk;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    rwvc_pkg::in_t  s_data    = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    rwvc_pkg::out_t m_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = '0;
    logic [31:0]    cfg_data  = '0;

    relay_write_verify_controller #(.READBACK_DELAY(READBACK_GAP)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predicted controller state
    // ------------------------------------------------------------------
    logic             tgt_on;
    logic [31:0]      tgt_gen;
    logic             want_write, rb_next;
    rwvc_pkg::kind_t  pend_kind, prep_kind;
    logic             prep_val;
    logic [31:0]      prep_gen, pend_gen, sent_gen_q, done_tick;
    rwvc_pkg::delay_t wait_sel;
    logic             got_resp, got_read;
    logic [31:0]      resp_tick, read_tick;
    logic             coil_rb, match_flag;
    logic [1:0]       res_code;
    logic             res_seen;
    logic [31:0]      tally [rwvc_pkg::NUM_COUNTERS];
    logic [30:0]      poll_ival, retry_ival, stale_ival;

    rwvc_pkg::out_t expected_q [$];
    int             mismatches   = 0;
    int             result_no    = 0;
    int             quiet        = 0;
    int             sent_count   = 0;
    int             send_gap_pct = 0;
    int             take_gap_pct = 0;
    logic [2:0]     dir_sel      = '0;
    logic [31:0]    clk_ms       = 32'hFFFF_F000;
    rwvc_pkg::out_t want;
    string          diff;

    task automatic predictor_reset();
        tgt_on     = 1'b0;
        tgt_gen    = 32'd1;
        want_write = 1'b1;
        rb_next    = 1'b0;
        pend_kind  = rwvc_pkg::KIND_IDLE;
        prep_kind  = rwvc_pkg::KIND_IDLE;
        prep_val   = 1'b0;
        prep_gen   = '0;
        pend_gen   = '0;
        sent_gen_q = '0;
        done_tick  = '0;
        wait_sel   = rwvc_pkg::DLY_POLL;
        got_resp   = 1'b0;
        got_read   = 1'b0;
        resp_tick  = '0;
        read_tick  = '0;
        coil_rb    = 1'b0;
        match_flag = 1'b0;
        res_code   = rwvc_pkg::RES_OK;
        res_seen   = 1'b0;
        for (int i = 0; i < rwvc_pkg::NUM_COUNTERS; i++) tally[i] = '0;
        poll_ival  = rwvc_pkg::POLL_RESET;
        retry_ival = rwvc_pkg::RETRY_RESET;
        stale_ival = rwvc_pkg::STALE_RESET;
    endtask

    function automatic logic [31:0] current_wait();
        case (wait_sel)
            rwvc_pkg::DLY_RETRY:    return {1'b0, retry_ival};
            rwvc_pkg::DLY_READBACK: return 32'(READBACK_GAP);
            default:                return {1'b0, poll_ival};
        endcase
    endfunction

    // request finished: pick the hold-off before the next one
    task automatic complete(input logic [31:0] now, input logic timed_out);
        rb_next   = (pend_kind == rwvc_pkg::KIND_WRITE);
        pend_kind = rwvc_pkg::KIND_IDLE;
        done_tick = now;
        if (timed_out)    wait_sel = rwvc_pkg::DLY_RETRY;
        else if (rb_next) wait_sel = rwvc_pkg::DLY_READBACK;
        else              wait_sel = rwvc_pkg::DLY_POLL;
    endtask

    task automatic apply_event(input rwvc_pkg::in_t ev, output rwvc_pkg::out_t res);
        logic        took;
        logic [2:0]  fst;
        logic [1:0]  code;
        logic [31:0] age;
        took = 1'b0;
        case (ev.command)
            rwvc_pkg::CMD_SET_TARGET: begin
                if (tgt_on != ev.wanted_on) begin
                    tgt_on     = ev.wanted_on;
                    tgt_gen    = tgt_gen + 32'd1;
                    match_flag = 1'b0;
                    want_write = 1'b1;
                    took       = 1'b1;
                end
            end
            rwvc_pkg::CMD_PREPARE: begin
                age = ev.now_tick - done_tick;
                if (pend_kind == rwvc_pkg::KIND_IDLE && age >= current_wait()) begin
                    prep_gen = tgt_gen;
                    if (want_write && !rb_next) begin
                        prep_kind = rwvc_pkg::KIND_WRITE;
                        prep_val  = tgt_on;
                    end else begin
                        prep_kind = rwvc_pkg::KIND_READ;
                    end
                    took = 1'b1;
                end
            end
            rwvc_pkg::CMD_SENT: begin
                if (pend_kind == rwvc_pkg::KIND_IDLE && prep_kind != rwvc_pkg::KIND_IDLE) begin
                    pend_kind = prep_kind;
                    prep_kind = rwvc_pkg::KIND_IDLE;
                    pend_gen  = prep_gen;
                    if (pend_kind == rwvc_pkg::KIND_WRITE) begin
                        tally[rwvc_pkg::CNT_WRITE] += 1;
                        sent_gen_q = pend_gen;
                        match_flag = 1'b0;
                    end
                    took = 1'b1;
                end
            end
            rwvc_pkg::CMD_FRAME: begin
                fst = ev.frame_status;
                if (pend_kind != rwvc_pkg::KIND_IDLE && fst != rwvc_pkg::FST_FOREIGN &&
                    !(fst == rwvc_pkg::FST_ECHO && pend_kind == rwvc_pkg::KIND_READ)) begin
                    // a write reply is an echo of the request
                    if (fst == rwvc_pkg::FST_ECHO) fst = rwvc_pkg::FST_OK;
                    code     = (fst <= rwvc_pkg::FST_OTHER) ? fst[1:0] : rwvc_pkg::RES_OTHER;
                    res_seen = 1'b1;
                    res_code = code;
                    if (code == rwvc_pkg::RES_OK) begin
                        got_resp  = 1'b1;
                        resp_tick = ev.rx_tick;
                        if (pend_kind == rwvc_pkg::KIND_WRITE) begin
                            tally[rwvc_pkg::CNT_ACK] += 1;
                        end else begin
                            got_read                    = 1'b1;
                            tally[rwvc_pkg::CNT_READ]  += 1;
                            tally[rwvc_pkg::CNT_ERRRUN] = '0;
                            read_tick                   = ev.rx_tick;
                            coil_rb                     = ev.read_bit;
                            match_flag = (pend_gen == tgt_gen) && (sent_gen_q == tgt_gen) &&
                                         (coil_rb == tgt_on);
                            want_write = !match_flag;
                        end
                    end else begin
                        tally[rwvc_pkg::CNT_ERRRUN] += 1;
                        tally[rwvc_pkg::CNT_PARSE]  += 1;
                        if (code == rwvc_pkg::RES_CRC) tally[rwvc_pkg::CNT_CRC] += 1;
                    end
                    complete(ev.now_tick, 1'b0);
                    took = 1'b1;
                end
            end
            rwvc_pkg::CMD_TIMEOUT: begin
                if (pend_kind != rwvc_pkg::KIND_IDLE) begin
                    tally[rwvc_pkg::CNT_TIMEOUT] += 1;
                    tally[rwvc_pkg::CNT_ERRRUN]  += 1;
                    complete(ev.now_tick, 1'b1);
                    took = 1'b1;
                end
            end
            rwvc_pkg::CMD_STATUS: took = 1'b1;
            default: ;
        endcase

        res               = '0;
        res.accepted      = took;
        res.request_kind  = prep_kind;
        res.request_value = (prep_kind == rwvc_pkg::KIND_WRITE) ? prep_val : 1'b0;
        res.pending_kind  = pend_kind;
        age               = ev.now_tick - resp_tick;
        res.online        = got_resp && (age <= {1'b0, stale_ival});
        age               = ev.now_tick - read_tick;
        res.sample_fresh  = got_read && (age <= {1'b0, stale_ival});
        res.verified      = res.sample_fresh && match_flag;
        res.observed_state = coil_rb;
        res.target_state  = tgt_on;
        res.last_result   = res_code;
        res.result_valid  = res_seen;
        res.counter_value = (ev.counter_select < rwvc_pkg::NUM_COUNTERS)
                            ? tally[ev.counter_select] : tgt_gen;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic rwvc_pkg::in_t evt(input logic [2:0] cmd, input logic w,
                                          input logic [31:0] now, input logic [31:0] ft,
                                          input logic [2:0] fs, input logic rb,
                                          input logic [2:0] sel);
        rwvc_pkg::in_t ev;
        ev.command        = cmd;
        ev.wanted_on      = w;
        ev.now_tick       = now;
        ev.rx_tick        = ft;
        ev.frame_status   = fs;
        ev.read_bit       = rb;
        ev.counter_select = sel;
        return ev;
    endfunction

    function automatic logic [2:0] rand3();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic rand1();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic post_event(input rwvc_pkg::in_t ev);
        rwvc_pkg::out_t res;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_event(ev, res);
        expected_q.push_back(res);
        sent_count++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            rwvc_pkg::CFG_POLL:  poll_ival  = val[30:0];
            rwvc_pkg::CFG_RETRY: retry_ival = val[30:0];
            rwvc_pkg::CFG_STALE: stale_ival = val[30:0];
            default: ;
        endcase
    endtask

    task automatic program_intervals(input logic [31:0] poll, input logic [31:0] retry,
                                     input logic [31:0] stale);
        drain_results();
        repeat (4) @(posedge aclk);   // pipeline settles
        reg_write(rwvc_pkg::CFG_POLL, poll);
        reg_write(rwvc_pkg::CFG_RETRY, retry);
        reg_write(rwvc_pkg::CFG_STALE, stale);
        reg_write(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_step(input logic [2:0] cmd, input logic w, input logic [31:0] now,
                                 input logic [31:0] ft, input logic [2:0] fs, input logic rb);
        post_event(evt(cmd, w, now, ft, fs, rb, dir_sel));
        dir_sel = dir_sel + 3'd1;
    endtask

    function automatic logic [2:0] pick_status();
        int r = $urandom_range(0, 99);
        if (r < 55) return rwvc_pkg::FST_OK;
        if (r < 65) return rwvc_pkg::FST_ECHO;
        if (r < 73) return FST_BADLEN;
        if (r < 81) return FST_CRC;
        if (r < 86) return rwvc_pkg::FST_OTHER;
        if (r < 91) return rwvc_pkg::FST_FOREIGN;
        return (r < 96) ? FST_RSVD_6 : FST_RSVD_7;
    endfunction

    // one prepare / send / response round with random content
    task automatic random_transaction();
        logic [31:0] span;
        logic        rb;
        int          tries;
        span = {1'b0, (poll_ival > retry_ival) ? poll_ival : retry_ival};
        if (span < 32'(READBACK_GAP)) span = 32'(READBACK_GAP);

        if ($urandom_range(0, 99) < 8) begin
            post_event(evt(rand3(), rand1(), $urandom, $urandom, rand3(), rand1(), rand3()));
            return;
        end
        if ($urandom_range(0, 4) == 0)
            post_event(evt(rwvc_pkg::CMD_SET_TARGET, rand1(), clk_ms, $urandom,
                           rand3(), rand1(), rand3()));

        if ($urandom_range(0, 3) != 0) clk_ms += span + $urandom_range(0, 3);
        else                           clk_ms += $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0) clk_ms += $urandom_range(0, 4 * stale_ival + 4);

        post_event(evt(rwvc_pkg::CMD_PREPARE, rand1(), clk_ms, $urandom,
                       rand3(), rand1(), rand3()));
        if (prep_kind == rwvc_pkg::KIND_IDLE) return;
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0)
                post_event(evt(rwvc_pkg::CMD_SET_TARGET, !tgt_on, clk_ms, $urandom,
                               rand3(), rand1(), rand3()));
            post_event(evt(rwvc_pkg::CMD_PREPARE, rand1(), clk_ms, $urandom,
                           rand3(), rand1(), rand3()));
        end
        post_event(evt(rwvc_pkg::CMD_SENT, rand1(), clk_ms, $urandom,
                       rand3(), rand1(), rand3()));
        if ($urandom_range(0, 9) == 0)
            post_event(evt(rwvc_pkg::CMD_STATUS, rand1(), clk_ms, $urandom,
                           rand3(), rand1(), rand3()));
        if ($urandom_range(0, 9) == 0)
            post_event(evt(rwvc_pkg::CMD_PREPARE, rand1(), clk_ms, $urandom,
                           rand3(), rand1(), rand3()));

        tries = 0;
        while (pend_kind != rwvc_pkg::KIND_IDLE && tries < 3) begin
            clk_ms += $urandom_range(0, 3);
            rb = (pend_kind == rwvc_pkg::KIND_READ && $urandom_range(0, 3) != 0) ? tgt_on
                                                                                   : rand1();
            if ($urandom_range(0, 99) < 15)
                post_event(evt(rwvc_pkg::CMD_TIMEOUT, rand1(), clk_ms, $urandom,
                               rand3(), rb, rand3()));
            else
                post_event(evt(rwvc_pkg::CMD_FRAME, rand1(), clk_ms,
                               clk_ms - $urandom_range(0, 2), pick_status(), rb, rand3()));
            tries++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_events();
        send_gap_pct = 32;
        take_gap_pct = 60;
        directed_step(rwvc_pkg::CMD_STATUS, 1'b0, 32'h0, 32'h0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(CMD_BAD_LO, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FST_RSVD_7, 1'b1);
        directed_step(CMD_BAD_HI, 1'b1, 32'hFFFF_FFFF, 32'h0, FST_RSVD_6, 1'b1);
        // same target
        directed_step(rwvc_pkg::CMD_SET_TARGET, 1'b0, 32'd5, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        // too early
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd10, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        // nothing prepared
        directed_step(rwvc_pkg::CMD_SENT, 1'b0, 32'd11, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        // frame and timeout while idle
        directed_step(rwvc_pkg::CMD_FRAME, 1'b0, 32'd12, 32'd12, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_TIMEOUT, 1'b0, 32'd13, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd1000, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_SET_TARGET, 1'b1, 32'd1000, 32'd0, rwvc_pkg::FST_OK,
                      1'b0);
        // replaces the prepared request
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd1001, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_SENT, 1'b0, 32'd1002, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        // both ignored while pending
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd1003, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_SENT, 1'b0, 32'd1003, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_FRAME, 1'b0, 32'd1004, 32'd1004,
                      rwvc_pkg::FST_FOREIGN, 1'b0);
        // write ack by echo
        directed_step(rwvc_pkg::CMD_FRAME, 1'b0, 32'd1005, 32'd1004,
                      rwvc_pkg::FST_ECHO, 1'b0);
        // readback gap not yet over
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd1007, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd1008, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_SENT, 1'b0, 32'd1008, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        // echo while a read is pending
        directed_step(rwvc_pkg::CMD_FRAME, 1'b0, 32'd1009, 32'd1009,
                      rwvc_pkg::FST_ECHO, 1'b0);
        directed_step(rwvc_pkg::CMD_FRAME, 1'b0, 32'd1010, 32'd1010,
                      rwvc_pkg::FST_OK, 1'b1);
        // age equal to the stale limit
        directed_step(rwvc_pkg::CMD_STATUS, 1'b0, 32'd4010, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd2010, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_SENT, 1'b0, 32'd2011, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_TIMEOUT, 1'b0, 32'd2020, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_PREPARE, 1'b0, 32'd2220, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_SENT, 1'b0, 32'd2221, 32'd0, rwvc_pkg::FST_OK, 1'b0);
        directed_step(rwvc_pkg::CMD_FRAME, 1'b0, 32'd2222, 32'd2222, FST_CRC, 1'b0);
    endtask

    task automatic test_random_traffic(input logic [31:0] poll, input logic [31:0] retry,
                                       input logic [31:0] stale, input int send_pct,
                                       input int take_pct, input int count);
        int goal;
        program_intervals(poll, retry, stale);
        send_gap_pct = send_pct;
        take_gap_pct = take_pct;
        goal = sent_count + count;
        while (sent_count < goal) random_transaction();
    endtask

    // largest intervals: exercise the hold-off boundary, then a short random run
    task automatic test_extreme_intervals();
        logic [31:0] bound;
        int          goal;
        program_intervals(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        if (pend_kind != rwvc_pkg::KIND_IDLE)
            post_event(evt(rwvc_pkg::CMD_TIMEOUT, 1'b0, clk_ms, 32'h0, rwvc_pkg::FST_OK, 1'b0,
                           rwvc_pkg::CNT_TIMEOUT));
        bound = current_wait();
        post_event(evt(rwvc_pkg::CMD_PREPARE, 1'b0, done_tick + bound - 1, 32'h0,
                       rwvc_pkg::FST_OK, 1'b0, rwvc_pkg::CNT_WRITE));
        clk_ms = done_tick + bound;
        post_event(evt(rwvc_pkg::CMD_PREPARE, 1'b0, clk_ms, 32'h0, rwvc_pkg::FST_OK, 1'b0,
                       rwvc_pkg::CNT_READ));
        goal = sent_count + 40;
        while (sent_count < goal) random_transaction();
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------
    function automatic string field_diff(input rwvc_pkg::out_t e, input rwvc_pkg::out_t a);
        string s = "";
        if (e.accepted !== a.accepted)
            s = {s, $sformatf(" accepted %0b/%0b", e.accepted, a.accepted)};
        if (e.request_kind !== a.request_kind)
            s = {s, $sformatf(" request_kind %0d/%0d", e.request_kind, a.request_kind)};
        if (e.request_value !== a.request_value)
            s = {s, $sformatf(" request_value %0b/%0b", e.request_value, a.request_value)};
        if (e.pending_kind !== a.pending_kind)
            s = {s, $sformatf(" pending_kind %0d/%0d", e.pending_kind, a.pending_kind)};
        if (e.online !== a.online)
            s = {s, $sformatf(" online %0b/%0b", e.online, a.online)};
        if (e.sample_fresh !== a.sample_fresh)
            s = {s, $sformatf(" sample_fresh %0b/%0b", e.sample_fresh, a.sample_fresh)};
        if (e.verified !== a.verified)
            s = {s, $sformatf(" verified %0b/%0b", e.verified, a.verified)};
        if (e.observed_state !== a.observed_state)
            s = {s, $sformatf(" observed_state %0b/%0b", e.observed_state, a.observed_state)};
        if (e.target_state !== a.target_state)
            s = {s, $sformatf(" target_state %0b/%0b", e.target_state, a.target_state)};
        if (e.last_result !== a.last_result)
            s = {s, $sformatf(" last_result %0d/%0d", e.last_result, a.last_result)};
        if (e.result_valid !== a.result_valid)
            s = {s, $sformatf(" result_valid %0b/%0b", e.result_valid, a.result_valid)};
        if (e.counter_value !== a.counter_value)
            s = {s, $sformatf(" counter_value %0h/%0h", e.counter_value, a.counter_value)};
        return s;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= take_gap_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_no++;
            if (expected_q.size() == 0) begin
                note_failure($sformatf("result %0d arrived with none expected", result_no));
            end else begin
                want = expected_q.pop_front();
                diff = field_diff(want, m_data);
                if (diff != "")
                    note_failure($sformatf("result %0d mismatch (expected/actual):%s",
                                           result_no, diff));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("FAIL relay_write_verify_controller");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        predictor_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_events();
        test_random_traffic(32'd20, 32'd10, 32'd60, 32, 60, 620);
        test_random_traffic(32'h8000_0001, 32'd1, 32'd1, 60, 32, 620);
        test_random_traffic(32'd7, 32'd45, 32'd25, 0, 0, 620);
        test_extreme_intervals();

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS relay_write_verify_controller");
        end else begin
            $display("FAIL relay_write_verify_controller");
        end
        $finish;
    end

endmodule

// ===== relay_write_verify_controller.f =====
rtl/rwvc_pkg.sv
rtl/rwvc_core.sv
rtl/relay_write_verify_controller.sv
tb/tb_relay_write_verify_controller.sv
